// ===== src/lvct_pkg.sv =====
package lvct_pkg;

	localparam int TABLE_ENTRIES   = 1024;
	localparam int THREAD_TAG_BITS = 3;
	localparam int IDX_W           = $clog2(TABLE_ENTRIES);
	localparam int CNT_W           = 8;
	localparam int ENTRY_W         = THREAD_TAG_BITS + CNT_W;

	localparam logic [0:0] FUNC_LOOKUP = 1'b0;
	localparam logic [0:0] FUNC_TRAIN  = 1'b1;

	localparam logic [1:0] CFG_COUNTER_BITS = 2'd0;
	localparam logic [1:0] CFG_CLEAR_CONST  = 2'd1;
	localparam logic [1:0] CFG_UPDATE_RULE  = 2'd2;

	localparam logic [1:0] RULE_PLAIN   = 2'd0;
	localparam logic [1:0] RULE_STRIDE  = 2'd1;
	localparam logic [1:0] RULE_CONTEXT = 2'd2;

	localparam logic [1:0] CLS_STRONG_UNPRED = 2'd0;
	localparam logic [1:0] CLS_WEAK_UNPRED   = 2'd1;
	localparam logic [1:0] CLS_PREDICTABLE   = 2'd2;
	localparam logic [1:0] CLS_CONSTANT      = 2'd3;

	typedef logic [THREAD_TAG_BITS-1:0] tag_t;
	typedef logic [CNT_W-1:0]           cnt_t;
	typedef logic [IDX_W-1:0]           idx_t;

	typedef struct packed {
		tag_t tag;
		cnt_t cnt;
	} entry_t;

	// The top bit of a saturated counter decides between weak and predictable.
	function automatic logic [1:0] classify(input cnt_t v, input logic [3:0] bits);
		logic [2:0] top;
		top = 3'(bits - 4'd1);
		if (v == '0) begin
			return CLS_STRONG_UNPRED;
		end else if (!v[top]) begin
			return CLS_WEAK_UNPRED;
		end else begin
			return CLS_PREDICTABLE;
		end
	endfunction

endpackage

// ===== src/load_value_classification_table_core.sv =====
// Channel   Signals                                   Width per field
// in        in_valid/in_ready, func..has_context      1,3,64,2,1,64,1
// out       out_valid/out_ready, classification       2
// cfg       cfg_we, cfg_index, cfg_data               1,2,4
//
// One beat per cycle is accepted unless a stalled result holds stage 1; each beat
// passes stage 1 and then the output register. The table sits in one RAM with a
// registered read; the read-modify-write of a training beat is closed by forwarding
// the last write into stage 1. After reset the block zeroes all 1024 table entries,
// one entry per cycle, with in_ready low; configuration writes are taken during
// that time. A stalled result holds stage 1, and in_ready then drops.
module load_value_classification_table_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        func,
	input  logic [2:0]  thread_id,
	input  logic [63:0] load_pc,
	input  logic [1:0]  used_class,
	input  logic        was_correct,
	input  logic [63:0] stride,
	input  logic        has_context,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  classification,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [3:0]  cfg_data
);

	// Configuration registers
	logic [3:0] cnt_bits_q;
	logic       clr_const_q;
	logic [1:0] rule_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_bits_q  <= 4'd2;
			clr_const_q <= 1'b0;
			rule_q      <= lvct_pkg::RULE_PLAIN;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lvct_pkg::CFG_COUNTER_BITS: cnt_bits_q  <= cfg_data;
				lvct_pkg::CFG_CLEAR_CONST:  clr_const_q <= cfg_data[0];
				lvct_pkg::CFG_UPDATE_RULE:  rule_q      <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// Clearing pass
	logic             clearing_q;
	lvct_pkg::idx_t   clr_idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clearing_q) begin
			clr_idx_q <= clr_idx_q + 1'b1;
			if (clr_idx_q == lvct_pkg::IDX_W'(lvct_pkg::TABLE_ENTRIES - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	// Stage 1 and output register handshake
	logic v_s1;
	logic adv;
	logic out_valid_q;
	logic accept;

	assign adv      = v_s1 && (!out_valid_q || out_ready);
	assign in_ready = !clearing_q && (!v_s1 || adv);
	assign accept   = in_valid && in_ready;

	logic                 func_s1;
	lvct_pkg::tag_t       tag_s1;
	lvct_pkg::idx_t       idx_s1;
	logic [1:0]           used_s1;
	logic                 correct_s1;
	logic                 stride_nz_s1;
	logic                 ctx_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (adv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1      <= func;
			tag_s1       <= thread_id[lvct_pkg::THREAD_TAG_BITS-1:0];
			idx_s1       <= load_pc[lvct_pkg::IDX_W-1:0];
			used_s1      <= used_class;
			correct_s1   <= was_correct;
			stride_nz_s1 <= (stride != 64'd0);
			ctx_s1       <= has_context;
		end
	end

	// Table memory
	logic                          ram_we;
	lvct_pkg::idx_t                ram_waddr;
	lvct_pkg::entry_t              ram_wdata;
	logic [lvct_pkg::ENTRY_W-1:0]  ram_rdata;
	lvct_pkg::entry_t              upd_wdata;
	logic                          upd_we;

	assign ram_we    = clearing_q || upd_we;
	assign ram_waddr = clearing_q ? clr_idx_q : idx_s1;
	assign ram_wdata = clearing_q ? lvct_pkg::entry_t'('0) : upd_wdata;

	lvct_ram #(
		.WIDTH(lvct_pkg::ENTRY_W),
		.DEPTH(lvct_pkg::TABLE_ENTRIES)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (accept),
		.raddr(load_pc[lvct_pkg::IDX_W-1:0]),
		.rdata(ram_rdata)
	);

	// Last write, forwarded to a read that was issued in the same cycle
	logic             wr_vld_q;
	lvct_pkg::idx_t   wr_idx_q;
	lvct_pkg::entry_t wr_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_vld_q <= 1'b0;
		end else if (upd_we) begin
			wr_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (upd_we) begin
			wr_idx_q  <= idx_s1;
			wr_data_q <= upd_wdata;
		end
	end

	// Classification and update
	lvct_pkg::entry_t cur;
	logic [3:0]       bits_eff;
	lvct_pkg::cnt_t   maxv;
	lvct_pkg::cnt_t   v_sat;
	lvct_pkg::cnt_t   v_new;
	lvct_pkg::cnt_t   v_inc;
	logic             match;
	logic [1:0]       res;

	always_comb begin
		if (wr_vld_q && wr_idx_q == idx_s1) begin
			cur = wr_data_q;
		end else begin
			cur = lvct_pkg::entry_t'(ram_rdata);
		end

		if (cnt_bits_q == 4'd0) begin
			bits_eff = 4'd1;
		end else if (cnt_bits_q > 4'd8) begin
			bits_eff = 4'd8;
		end else begin
			bits_eff = cnt_bits_q;
		end

		maxv  = 8'hFF >> (4'd8 - bits_eff);
		v_sat = (cur.cnt > maxv) ? maxv : cur.cnt;
		v_inc = (v_sat < maxv) ? v_sat + 8'd1 : v_sat;
		match = (cur.tag == tag_s1);

		if (!match) begin
			v_new = '0;
		end else if (!correct_s1) begin
			if (used_s1 == lvct_pkg::CLS_CONSTANT && clr_const_q) begin
				v_new = '0;
			end else if (v_sat != '0) begin
				v_new = v_sat - 8'd1;
			end else begin
				v_new = v_sat;
			end
		end else begin
			case (rule_q)
				lvct_pkg::RULE_STRIDE: begin
					// A saturated counter backs off by one while the stride is nonzero.
					if (v_inc == maxv && stride_nz_s1) begin
						v_new = v_inc - 8'd1;
					end else begin
						v_new = v_inc;
					end
				end
				lvct_pkg::RULE_CONTEXT: v_new = ctx_s1 ? v_inc : v_sat;
				default: v_new = v_inc;
			endcase
		end

		if (func_s1 == lvct_pkg::FUNC_LOOKUP) begin
			res = match ? lvct_pkg::classify(v_sat, bits_eff) : lvct_pkg::CLS_STRONG_UNPRED;
		end else begin
			res = lvct_pkg::classify(v_new, bits_eff);
		end

		upd_we        = adv && (func_s1 == lvct_pkg::FUNC_TRAIN);
		upd_wdata.tag = tag_s1;
		upd_wdata.cnt = v_new;
	end

	// Output register
	logic [1:0] class_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			class_q <= res;
		end
	end

	assign out_valid      = out_valid_q;
	assign classification = class_q;

`ifndef SYNTHESIS
	a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> !clearing_q)
		else $error("input beat accepted during the clearing pass");

	a_clear_done_stays: assert property (@(posedge clk) disable iff (!arst_n)
		!clearing_q |=> !clearing_q)
		else $error("clearing pass restarted");

	a_stalled_stage_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !adv) |=> (v_s1 && $stable(idx_s1) && $stable(func_s1)))
		else $error("stage 1 changed while stalled");

	a_result_code_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (class_q != lvct_pkg::CLS_CONSTANT))
		else $error("result carries the constant class code");

	a_train_writes_once: assert property (@(posedge clk) disable iff (!arst_n)
		upd_we |-> (adv && !clearing_q))
		else $error("table update outside an advancing training beat");
`endif

endmodule

// ===== src/lvct_ram.sv =====
module lvct_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// A read at the address being written returns the old contents.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== dv/lvct_class_checker.sv =====
`timescale 1ns / 1ps

module lvct_class_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic        func,
	input  logic [2:0]  thread_id,
	input  logic [63:0] load_pc,
	input  logic [1:0]  used_class,
	input  logic        was_correct,
	input  logic [63:0] stride,
	input  logic        has_context,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [1:0]  classification,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [3:0]  cfg_data,
	output int          fail_count,
	output int          pending
);

	lvct_pkg::cnt_t conf_cnt  [lvct_pkg::TABLE_ENTRIES];
	lvct_pkg::tag_t owner_tag [lvct_pkg::TABLE_ENTRIES];
	logic [3:0]     width_cfg;
	logic           clear_cfg;
	logic [1:0]     rule_cfg;
	logic [1:0]     pending_classes [$];
	logic [1:0]     due_class;
	int             mismatches = 0;

	assign fail_count = mismatches;

	function automatic logic [1:0] grade(input int unsigned v, input int unsigned bits);
		if (v == 0) begin
			return lvct_pkg::CLS_STRONG_UNPRED;
		end
		if (((v >> (bits - 1)) & 1) == 0) begin
			return lvct_pkg::CLS_WEAK_UNPRED;
		end
		return lvct_pkg::CLS_PREDICTABLE;
	endfunction

	// Applies one beat to the shadow table and returns the class it must produce.
	function automatic logic [1:0] next_class(input logic fn, input lvct_pkg::tag_t tid,
			input lvct_pkg::idx_t slot, input logic [1:0] used, input logic ok,
			input logic stride_nz, input logic ctx);
		int unsigned bits;
		int unsigned top_val;
		int unsigned v;
		logic        hit;
		bits = (width_cfg == 0) ? 1 : ((width_cfg > 8) ? 8 : width_cfg);
		top_val = (1 << bits) - 1;
		v = conf_cnt[slot];
		hit = owner_tag[slot] == tid;
		// A counter left over from a wider setting reads as saturated.
		if (v > top_val) begin
			v = top_val;
		end
		if (fn == lvct_pkg::FUNC_LOOKUP) begin
			return hit ? grade(v, bits) : lvct_pkg::CLS_STRONG_UNPRED;
		end
		if (!hit) begin
			owner_tag[slot] = tid;
			v = 0;
		end else if (!ok) begin
			if (used == lvct_pkg::CLS_CONSTANT && clear_cfg) begin
				v = 0;
			end else if (v > 0) begin
				v--;
			end
		end else if (rule_cfg == lvct_pkg::RULE_STRIDE) begin
			if (v < top_val) begin
				v++;
			end
			if (v == top_val && stride_nz) begin
				v--;
			end
		end else if (rule_cfg == lvct_pkg::RULE_CONTEXT) begin
			if (ctx && v < top_val) begin
				v++;
			end
		end else if (v < top_val) begin
			v++;
		end
		conf_cnt[slot] = lvct_pkg::cnt_t'(v);
		return grade(v, bits);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < lvct_pkg::TABLE_ENTRIES; i++) begin
				conf_cnt[i] = '0;
				owner_tag[i] = '0;
			end
			width_cfg = 4'd2;
			clear_cfg = 1'b0;
			rule_cfg = lvct_pkg::RULE_PLAIN;
			pending_classes.delete();
			pending <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					lvct_pkg::CFG_COUNTER_BITS: width_cfg = cfg_data;
					lvct_pkg::CFG_CLEAR_CONST:  clear_cfg = cfg_data[0];
					lvct_pkg::CFG_UPDATE_RULE:  rule_cfg = cfg_data[1:0];
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (pending_classes.size() == 0) begin
					mismatches++;
					$display("%0t: classification beat with none expected: expected none, actual %0d",
						$time, classification);
				end else begin
					due_class = pending_classes.pop_front();
					if (due_class !== classification) begin
						mismatches++;
						$display("%0t: classification mismatch: expected %0d, actual %0d",
							$time, due_class, classification);
					end
				end
			end
			if (in_valid && in_ready) begin
				pending_classes.push_back(next_class(func,
					thread_id[lvct_pkg::THREAD_TAG_BITS-1:0], load_pc[lvct_pkg::IDX_W-1:0],
					used_class, was_correct, stride != 64'd0, has_context));
			end
			pending <= pending_classes.size();
		end
	end

endmodule

// ===== dv/tb_load_value_classification_table_core.sv =====
`timescale 1ns / 1ps

module tb_load_value_classification_table_core;

	localparam int         WATCHDOG_LIMIT = 20000;
	localparam int         SETTLE_CYCLES  = 4;
	localparam int         PHASES         = 10;
	localparam logic [1:0] CFG_SPARE      = 2'd3;
	localparam logic [1:0] RULE_SPARE     = 2'd3;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic        func;
	logic [2:0]  thread_id;
	logic [63:0] load_pc;
	logic [1:0]  used_class;
	logic        was_correct;
	logic [63:0] stride;
	logic        has_context;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  classification;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [3:0]  cfg_data;

	int fail_count;
	int pending;
	int quiet_cycles = 0;
	int ready_hold = 0;
	bit gaps_on = 1'b0;

	// Settings per phase: counter width code, clear on constant miss, rule code,
	// number of hot slots, percent correct, percent foreign thread, beats.
	logic [3:0]  phase_bits    [PHASES] = '{4'd2, 4'd8, 4'd15, 4'd1, 4'd0,
	                                        4'd4, 4'd3, 4'd8, 4'd5, 4'd2};
	logic        phase_clear   [PHASES] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0,
	                                        1'b1, 1'b0, 1'b0, 1'b1, 1'b1};
	logic [1:0]  phase_rule    [PHASES] = '{lvct_pkg::RULE_PLAIN, lvct_pkg::RULE_STRIDE,
	                                        lvct_pkg::RULE_CONTEXT, RULE_SPARE,
	                                        lvct_pkg::RULE_STRIDE, lvct_pkg::RULE_CONTEXT,
	                                        lvct_pkg::RULE_PLAIN, RULE_SPARE,
	                                        lvct_pkg::RULE_STRIDE, lvct_pkg::RULE_CONTEXT};
	int          phase_pool    [PHASES] = '{4, 1, 1, 2, 3, 6, 8, 1, 4, 8};
	int          phase_correct [PHASES] = '{70, 97, 97, 60, 70, 75, 70, 95, 80, 60};
	int          phase_foreign [PHASES] = '{10, 0, 0, 10, 10, 15, 15, 2, 10, 25};
	int          phase_items   [PHASES] = '{120, 200, 150, 100, 100, 130, 130, 150, 110, 110};
	lvct_pkg::idx_t slot_pool  [8];

	always begin
		#2;
		clk = 1'b1;
		#2;
		clk = 1'b0;
	end

	load_value_classification_table_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.func(func), .thread_id(thread_id), .load_pc(load_pc), .used_class(used_class),
		.was_correct(was_correct), .stride(stride), .has_context(has_context),
		.out_valid(out_valid), .out_ready(out_ready), .classification(classification),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	lvct_class_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.func(func), .thread_id(thread_id), .load_pc(load_pc), .used_class(used_class),
		.was_correct(was_correct), .stride(stride), .has_context(has_context),
		.out_valid(out_valid), .out_ready(out_ready), .classification(classification),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending(pending)
	);

	// Mostly short pauses, now and then a long one.
	function automatic int pause_len();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
	endfunction

	always @(posedge clk) begin
		if (ready_hold > 0) begin
			ready_hold--;
		end else if (!gaps_on || $urandom_range(0, 2) != 0) begin
			out_ready <= 1'b1;
			ready_hold = $urandom_range(0, 12);
		end else begin
			out_ready <= 1'b0;
			ready_hold = pause_len();
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("load_value_classification_table_core test failed");
			$finish;
		end
	end

	task automatic drive_beat(input logic f, input logic [2:0] t, input logic [63:0] a,
			input logic [1:0] u, input logic c, input logic [63:0] s, input logic x);
		in_valid <= 1'b1;
		func <= f;
		thread_id <= t;
		load_pc <= a;
		used_class <= u;
		was_correct <= c;
		stride <= s;
		has_context <= x;
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
	endtask

	task automatic rest_input();
		int n;
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			n = pause_len();
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// Waits until every classification has come back and the pipeline is empty.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apply_setting(input logic [3:0] bits, input logic clr, input logic [1:0] rule);
		cfg_we <= 1'b1;
		cfg_index <= CFG_SPARE;
		cfg_data <= 4'($urandom);
		@(posedge clk);
		cfg_index <= lvct_pkg::CFG_COUNTER_BITS;
		cfg_data <= bits;
		@(posedge clk);
		cfg_index <= lvct_pkg::CFG_CLEAR_CONST;
		cfg_data <= {3'($urandom), clr};
		@(posedge clk);
		cfg_index <= lvct_pkg::CFG_UPDATE_RULE;
		cfg_data <= {2'($urandom), rule};
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		logic [63:0] all_ones;
		logic [63:0] addr;
		logic [63:0] step;
		logic [2:0]  tid_a;
		logic [2:0]  tid_b;
		logic [2:0]  tid;
		logic        op;
		logic        hit_ok;

		all_ones = '1;
		in_valid <= 1'b0;
		func <= lvct_pkg::FUNC_LOOKUP;
		thread_id <= '0;
		load_pc <= '0;
		used_class <= lvct_pkg::CLS_STRONG_UNPRED;
		was_correct <= 1'b0;
		stride <= '0;
		has_context <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= lvct_pkg::CFG_COUNTER_BITS;
		cfg_data <= '0;
		arst_n <= 1'b0;
		for (int k = 0; k < 8; k++) begin
			slot_pool[k] = lvct_pkg::idx_t'($urandom);
		end
		tid_a = 3'($urandom);
		tid_b = tid_a ^ 3'($urandom_range(1, 7));

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		apply_setting(4'd2, 1'b1, lvct_pkg::RULE_PLAIN);

		// Fresh entries, a foreign thread taking over the top slot, counting up to
		// saturation and past it, then a plain miss and a constant-class miss.
		drive_beat(lvct_pkg::FUNC_LOOKUP, 3'd0, 64'd0, lvct_pkg::CLS_STRONG_UNPRED, 1'b0,
			64'd0, 1'b0);
		drive_beat(lvct_pkg::FUNC_LOOKUP, 3'd7, all_ones, lvct_pkg::CLS_CONSTANT, 1'b1,
			all_ones, 1'b1);
		drive_beat(lvct_pkg::FUNC_TRAIN, 3'd7, all_ones, lvct_pkg::CLS_PREDICTABLE, 1'b1,
			all_ones, 1'b1);
		drive_beat(lvct_pkg::FUNC_TRAIN, 3'd7, all_ones, lvct_pkg::CLS_PREDICTABLE, 1'b1,
			64'd0, 1'b0);
		drive_beat(lvct_pkg::FUNC_TRAIN, 3'd7, all_ones, lvct_pkg::CLS_WEAK_UNPRED, 1'b1,
			all_ones, 1'b1);
		drive_beat(lvct_pkg::FUNC_TRAIN, 3'd7, all_ones, lvct_pkg::CLS_CONSTANT, 1'b1,
			64'd0, 1'b1);
		drive_beat(lvct_pkg::FUNC_TRAIN, 3'd7, all_ones, lvct_pkg::CLS_PREDICTABLE, 1'b1,
			all_ones, 1'b0);
		drive_beat(lvct_pkg::FUNC_LOOKUP, 3'd7, all_ones, lvct_pkg::CLS_PREDICTABLE, 1'b0,
			64'd0, 1'b0);
		drive_beat(lvct_pkg::FUNC_LOOKUP, 3'd0, all_ones, lvct_pkg::CLS_PREDICTABLE, 1'b0,
			64'd0, 1'b0);
		drive_beat(lvct_pkg::FUNC_TRAIN, 3'd7, all_ones, lvct_pkg::CLS_PREDICTABLE, 1'b0,
			64'd0, 1'b0);
		drive_beat(lvct_pkg::FUNC_TRAIN, 3'd7, all_ones, lvct_pkg::CLS_CONSTANT, 1'b0,
			all_ones, 1'b1);
		drive_beat(lvct_pkg::FUNC_TRAIN, 3'd7, all_ones, lvct_pkg::CLS_STRONG_UNPRED, 1'b0,
			64'd0, 1'b0);
		drive_beat(lvct_pkg::FUNC_TRAIN, 3'd0, 64'd0, lvct_pkg::CLS_WEAK_UNPRED, 1'b1,
			64'd1, 1'b0);
		drive_beat(lvct_pkg::FUNC_LOOKUP, 3'd0, 64'd1024, lvct_pkg::CLS_STRONG_UNPRED, 1'b0,
			64'd0, 1'b0);
		drain();

		for (int p = 0; p < PHASES; p++) begin
			gaps_on = (p % 3) != 2;
			apply_setting(phase_bits[p], phase_clear[p], phase_rule[p]);
			for (int i = 0; i < phase_items[p]; i++) begin
				if ($urandom_range(0, 9) == 0) begin
					drive_beat(1'($urandom), 3'($urandom), {$urandom, $urandom}, 2'($urandom),
						1'($urandom), {$urandom, $urandom}, 1'($urandom));
				end else begin
					// Hot slots with fresh upper address bits, so the same entries keep
					// getting trained by their owning thread.
					addr = {$urandom, $urandom};
					addr[lvct_pkg::IDX_W-1:0] = slot_pool[$urandom_range(0, phase_pool[p] - 1)];
					tid = ($urandom_range(0, 99) < phase_foreign[p]) ? tid_b : tid_a;
					op = ($urandom_range(0, 99) < 20) ? lvct_pkg::FUNC_LOOKUP
						: lvct_pkg::FUNC_TRAIN;
					hit_ok = $urandom_range(0, 99) < phase_correct[p];
					step = $urandom_range(0, 1) ? 64'd0 : {$urandom, $urandom};
					drive_beat(op, tid, addr, 2'($urandom), hit_ok, step, $urandom_range(0, 3) != 0);
				end
				rest_input();
			end
			drain();
		end

		if (fail_count == 0) begin
			$display("load_value_classification_table_core test passed");
		end else begin
			$display("load_value_classification_table_core test failed");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
src/lvct_pkg.sv
src/lvct_ram.sv
src/load_value_classification_table_core.sv
dv/lvct_class_checker.sv
dv/tb_load_value_classification_table_core.sv
